[sv/gdrc_pkg.sv]
// Shared types and constants for the grid DDA ray caster.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package gdrc_pkg;

    // Fixed field widths
    localparam int COL_W      = 11;
    localparam int CELL_W     = 5;
    localparam int VAL_W      = 3;
    localparam int ROW_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths
    localparam int DIV_NW   = 32;  // dividend and quotient
    localparam int DIV_DW   = 48;  // divisor
    localparam int DIST_W   = 48;  // side distances, Q16
    localparam int DELTA_W  = 41;  // per-cell distance, 2^40 marks an axis never crossed
    localparam int RAY_W    = 18;  // ray direction, Q14
    localparam int COORD_W  = 11;  // signed map coordinate while walking

    localparam logic [DELTA_W-1:0] DELTA_INF = {1'b1, {(DELTA_W-1){1'b0}}};
    localparam logic [DIV_NW-1:0]  RECIP_NUM = 32'h4000_0000;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM,
        S_RAY,
        S_RX_GO,
        S_RX_WAIT,
        S_RY_GO,
        S_RY_WAIT,
        S_SIDE,
        S_STEP,
        S_CHECK,
        S_HT_GO,
        S_HT_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DIV_RX,
        DIV_RY,
        DIV_HT
    } t_div_sel;

    typedef struct packed {
        logic     take_write;
        logic     take_cast;
        logic     cam_calc;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_capture;
        logic     ray_calc;
        logic     side_init;
        logic     step;
        logic     check;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic wall;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/gdrc_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on gdrc_pkg for the operand widths.
`default_nettype none

module gdrc_div import gdrc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic                   o_done,
    output logic      [DIV_NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_num, n_num;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den, n_den;
    logic [DIV_DW:0]   w_trial;
    logic              w_fit;

    // Shift in one dividend bit and try the subtract
    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_fit ? DIV_DW'(w_trial - {1'b0, r_den}) : DIV_DW'(w_trial);
            n_num = {r_num[DIV_NW-2:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

[sv/gdrc_dp.sv]
// Datapath: configuration registers, map memory, ray setup, DDA walk, wall span.
// Depends on gdrc_pkg and gdrc_div.
`default_nettype none

module gdrc_dp import gdrc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080,
    parameter int MAP_DIM       = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [COL_W-1:0]      i_column,
    input  wire logic [CELL_W-1:0]     i_cell_x,
    input  wire logic [CELL_W-1:0]     i_cell_y,
    input  wire logic [VAL_W-1:0]      i_cell_value,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic      [ROW_W-1:0]      o_draw_top,
    output logic      [ROW_W-1:0]      o_draw_bottom,
    output logic                       o_hit_side,
    output logic      [1:0]            o_color_code,
    output logic                       o_hit_found
);

    localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int LIN_W     = 20;
    localparam logic [COL_W-1:0]  COL_MAX = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [DIV_NW-1:0] HT_NUM  = DIV_NW'(SCREEN_HEIGHT * 65536);
    localparam logic [DIV_NW:0]   HALF_H  = (DIV_NW + 1)'(SCREEN_HEIGHT / 2);
    localparam logic [DIV_NW:0]   LAST_R  = (DIV_NW + 1)'(SCREEN_HEIGHT - 1);
    localparam logic [DIV_NW:0]   SCR_H   = (DIV_NW + 1)'(SCREEN_HEIGHT);
    // Reciprocal of the screen width; exact floor while col * 2^15 stays below 2^26
    localparam int          CAM_SH = 26 + $clog2(SCREEN_WIDTH);
    localparam logic [26:0] CAM_M  = 27'((64'd1 << CAM_SH) / 64'(SCREEN_WIDTH) + 64'd1);

    // Configuration registers
    logic        [14:0] r_player_x, r_player_y;
    logic signed [15:0] r_view_x, r_view_y, r_plane_x, r_plane_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= 15'd1024;
            r_player_y <= 15'd1024;
            r_view_x   <= -16'sd16384;
            r_view_y   <= 16'sd0;
            r_plane_x  <= 16'sd0;
            r_plane_y  <= 16'sd11469;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAYER_X: r_player_x <= i_cfg_wdata[14:0];
                CFG_PLAYER_Y: r_player_y <= i_cfg_wdata[14:0];
                CFG_VIEW_X:   r_view_x   <= i_cfg_wdata;
                CFG_VIEW_Y:   r_view_y   <= i_cfg_wdata;
                CFG_PLANE_X:  r_plane_x  <= i_cfg_wdata;
                CFG_PLANE_Y:  r_plane_y  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Working registers
    logic        [COL_W-1:0]   r_col;
    logic signed [15:0]        r_cam;
    logic signed [RAY_W-1:0]   r_rdx, r_rdy;
    logic        [DELTA_W-1:0] r_dx, r_dy;
    logic        [DIST_W-1:0]  r_sx, r_sy;
    logic signed [COORD_W-1:0] r_mx, r_my;
    logic                      r_side;
    logic                      r_oob;
    logic        [VAL_W-1:0]   r_rd;
    logic                      r_hit;
    logic        [DIV_NW-1:0]  r_height;
    logic        [ROW_W-1:0]   r_top, r_bot;
    logic                      r_out_side, r_out_hit;
    logic        [1:0]         r_out_color;
    logic        [VAL_W-1:0]   r_map [MAP_DEPTH];

    // Camera coordinate: floor(col * 2^15 / SCREEN_WIDTH) by reciprocal multiply
    logic [37:0] w_cam_prod;
    logic [14:0] w_cam_q;

    assign w_cam_prod = 38'(r_col) * 38'(CAM_M);
    assign w_cam_q    = w_cam_prod[CAM_SH-15 +: 15];

    // Ray direction: view + plane * cam, floored Q14
    logic signed [31:0]      w_prod_x, w_prod_y;
    logic signed [RAY_W-1:0] w_rdx, w_rdy;
    logic        [RAY_W-1:0] w_abs_x, w_abs_y;

    assign w_prod_x = r_plane_x * r_cam;
    assign w_prod_y = r_plane_y * r_cam;
    assign w_rdx    = RAY_W'(r_view_x) + RAY_W'(w_prod_x >>> 14);
    assign w_rdy    = RAY_W'(r_view_y) + RAY_W'(w_prod_y >>> 14);
    assign w_abs_x  = r_rdx[RAY_W-1] ? RAY_W'(-r_rdx) : RAY_W'(r_rdx);
    assign w_abs_y  = r_rdy[RAY_W-1] ? RAY_W'(-r_rdy) : RAY_W'(r_rdy);

    // Wall distance along the hit axis
    logic [DIST_W-1:0] w_dist;
    assign w_dist = r_side ? r_sy - DIST_W'(r_dy) : r_sx - DIST_W'(r_dx);

    // Shared divider operand select
    logic [DIV_NW-1:0] w_num, w_quot;
    logic [DIV_DW-1:0] w_den;
    logic              w_div_done;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_RX: begin
                w_num = RECIP_NUM;
                w_den = DIV_DW'(w_abs_x);
            end
            DIV_RY: begin
                w_num = RECIP_NUM;
                w_den = DIV_DW'(w_abs_y);
            end
            default: begin
                w_num = HT_NUM;
                w_den = DIV_DW'(w_dist);
            end
        endcase
    end

    gdrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Start side distances from the fraction to the next border
    logic [10:0] w_fx, w_fy;
    logic [41:0] w_px_prod, w_py_prod;

    assign w_fx = r_rdx[RAY_W-1] ? {1'b0, r_player_x[9:0]} : 11'd1024 - {1'b0, r_player_x[9:0]};
    assign w_fy = r_rdy[RAY_W-1] ? {1'b0, r_player_y[9:0]} : 11'd1024 - {1'b0, r_player_y[9:0]};
    assign w_px_prod = 42'(w_fx) * 42'(r_dx[30:0]);
    assign w_py_prod = 42'(w_fy) * 42'(r_dy[30:0]);

    // One DDA step: smaller side distance advances, y on a tie
    logic                      w_take_x;
    logic signed [COORD_W-1:0] w_nmx, w_nmy, w_sgx, w_sgy;
    logic                      w_oob;
    logic        [LIN_W-1:0]   w_rlin, w_wlin;
    logic                      w_wr_ok;

    assign w_take_x = r_sx < r_sy;
    assign w_sgx    = r_rdx[RAY_W-1] ? {COORD_W{1'b1}} : COORD_W'(1);
    assign w_sgy    = r_rdy[RAY_W-1] ? {COORD_W{1'b1}} : COORD_W'(1);
    assign w_nmx    = w_take_x ? r_mx + w_sgx : r_mx;
    assign w_nmy    = w_take_x ? r_my : r_my + w_sgy;
    assign w_oob    = w_nmx[COORD_W-1] || w_nmy[COORD_W-1] ||
                      (w_nmx >= MAP_DIM) || (w_nmy >= MAP_DIM);
    assign w_rlin   = LIN_W'(w_nmx[COORD_W-2:0]) * LIN_W'(MAP_DIM) +
                      LIN_W'(w_nmy[COORD_W-2:0]);
    assign w_wlin   = LIN_W'(i_cell_x) * LIN_W'(MAP_DIM) + LIN_W'(i_cell_y);
    assign w_wr_ok  = (int'(i_cell_x) < MAP_DIM) && (int'(i_cell_y) < MAP_DIM);

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_write && w_wr_ok) begin
            r_map[w_wlin[AW-1:0]] <= i_cell_value;
        end
        if (i_cmd.step) begin
            r_rd <= r_map[w_rlin[AW-1:0]];
        end
    end

    // Wall span from the height
    logic [DIV_NW:0] w_half, w_top, w_bot_sum, w_bot;
    assign w_half    = (DIV_NW + 1)'(r_height >> 1);
    assign w_top     = (w_half > HALF_H) ? '0 : HALF_H - w_half;
    assign w_bot_sum = HALF_H + w_half;
    assign w_bot     = (w_bot_sum >= SCR_H) ? LAST_R : w_bot_sum;

    // Register updates per command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.take_cast) begin
            r_hit <= 1'b0;
        end else if (i_cmd.check && o_stat.wall) begin
            r_hit <= 1'b1;
        end

        if (i_cmd.take_cast) begin
            r_col <= (int'(i_column) >= SCREEN_WIDTH) ? COL_MAX : i_column;
        end
        if (i_cmd.cam_calc) begin
            r_cam <= $signed({1'b0, w_cam_q}) - 16'sd16384;
        end
        if (i_cmd.ray_calc) begin
            r_rdx <= w_rdx;
            r_rdy <= w_rdy;
        end
        if (i_cmd.div_capture) begin
            case (i_cmd.div_sel)
                DIV_RX:  r_dx     <= (r_rdx == '0) ? DELTA_INF : DELTA_W'(w_quot);
                DIV_RY:  r_dy     <= (r_rdy == '0) ? DELTA_INF : DELTA_W'(w_quot);
                default: r_height <= (w_dist == '0) ? '0 : w_quot;
            endcase
        end
        if (i_cmd.side_init) begin
            r_sx <= r_dx[DELTA_W-1] ? DIST_W'({w_fx, 30'd0}) : DIST_W'(w_px_prod >> 10);
            r_sy <= r_dy[DELTA_W-1] ? DIST_W'({w_fy, 30'd0}) : DIST_W'(w_py_prod >> 10);
            r_mx <= COORD_W'(r_player_x[14:10]);
            r_my <= COORD_W'(r_player_y[14:10]);
        end
        if (i_cmd.step) begin
            if (w_take_x) begin
                r_sx <= r_sx + DIST_W'(r_dx);
            end else begin
                r_sy <= r_sy + DIST_W'(r_dy);
            end
            r_mx   <= w_nmx;
            r_my   <= w_nmy;
            r_side <= !w_take_x;
            r_oob  <= w_oob;
        end
        if (i_cmd.load_out) begin
            r_out_hit <= r_hit;
            if (r_hit) begin
                r_top       <= w_top[ROW_W-1:0];
                r_bot       <= w_bot[ROW_W-1:0];
                r_out_side  <= r_side;
                r_out_color <= {r_side, r_side ? !r_rdy[RAY_W-1] : !r_rdx[RAY_W-1]};
            end else begin
                r_top       <= '0;
                r_bot       <= '0;
                r_out_side  <= 1'b0;
                r_out_color <= '0;
            end
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.wall     = r_oob || (r_rd != '0);

    assign o_draw_top    = r_top;
    assign o_draw_bottom = r_bot;
    assign o_hit_side    = r_out_side;
    assign o_color_code  = r_out_color;
    assign o_hit_found   = r_out_hit;

endmodule

`default_nettype wire

[sv/gdrc_ctrl.sv]
// Controller: sequences setup divisions, the DDA walk and the output word.
// Depends on gdrc_pkg.
`default_nettype none

module gdrc_ctrl import gdrc_pkg::*; #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire logic     i_operation,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam int SC_W = $clog2(MAX_STEPS);

    t_state          r_state, n_state;
    logic [SC_W-1:0] r_steps;
    logic            r_out_valid;
    logic            w_accept, w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept && i_operation == OP_CAST) n_state = S_CAM;
            S_CAM:      n_state = S_RAY;
            S_RAY:      n_state = S_RX_GO;
            S_RX_GO:    n_state = S_RX_WAIT;
            S_RX_WAIT:  if (i_stat.div_done) n_state = S_RY_GO;
            S_RY_GO:    n_state = S_RY_WAIT;
            S_RY_WAIT:  if (i_stat.div_done) n_state = S_SIDE;
            S_SIDE:     n_state = S_STEP;
            S_STEP:     n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.wall) n_state = S_HT_GO;
                else if (r_steps == SC_W'(MAX_STEPS - 1)) n_state = S_FINISH;
                else n_state = S_STEP;
            end
            S_HT_GO:    n_state = S_HT_WAIT;
            S_HT_WAIT:  if (i_stat.div_done) n_state = S_FINISH;
            S_FINISH:   if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd             = '0;
        o_cmd.div_sel     = DIV_RX;
        o_cmd.take_write  = w_accept && i_operation == OP_WRITE;
        o_cmd.take_cast   = w_accept && i_operation == OP_CAST;
        unique case (r_state)
            S_CAM:      o_cmd.cam_calc = 1'b1;
            S_RAY:      o_cmd.ray_calc = 1'b1;
            S_RX_GO: begin
                o_cmd.div_sel   = DIV_RX;
                o_cmd.div_start = 1'b1;
            end
            S_RX_WAIT: begin
                o_cmd.div_sel     = DIV_RX;
                o_cmd.div_capture = i_stat.div_done;
            end
            S_RY_GO: begin
                o_cmd.div_sel   = DIV_RY;
                o_cmd.div_start = 1'b1;
            end
            S_RY_WAIT: begin
                o_cmd.div_sel     = DIV_RY;
                o_cmd.div_capture = i_stat.div_done;
            end
            S_SIDE:     o_cmd.side_init = 1'b1;
            S_STEP:     o_cmd.step = 1'b1;
            S_CHECK:    o_cmd.check = 1'b1;
            S_HT_GO: begin
                o_cmd.div_sel   = DIV_HT;
                o_cmd.div_start = 1'b1;
            end
            S_HT_WAIT: begin
                o_cmd.div_sel     = DIV_HT;
                o_cmd.div_capture = i_stat.div_done;
            end
            S_FINISH:   o_cmd.load_out = w_out_free;
            default: ;
        endcase
    end

    // State, step count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SIDE) begin
                r_steps <= '0;
            end else if (r_state == S_CHECK) begin
                r_steps <= r_steps + 1'b1;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // A pending word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_cmd.load_out)
        else $error("output word overwritten while stalled");

    // Divider started only from a start state and idle afterwards
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !o_cmd.div_start)
        else $error("divider restarted back to back");

    // Capture only with a finished quotient
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_capture |-> i_stat.div_done)
        else $error("quotient captured before done");

endmodule

`default_nettype wire

[sv/grid_dda_ray_caster.sv]
// Top level of the grid DDA ray caster: controller plus datapath.
// Depends on gdrc_pkg, gdrc_ctrl, gdrc_dp (which holds gdrc_div).
//
//  channel  direction  handshake            word
//  input    in         i_valid / o_ready    operation, column, cell_x/y, cell_value
//  output   out        o_valid / i_ready    draw_top, draw_bottom, hit_side, color, hit
//  config   in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// A map write is done when it is taken. A cast that meets a wall gives its word after
// three passes of the shared radix-2 divider (two reciprocals, the height), a map read
// per cell walked and the setup and load states. A ray that meets no wall skips the
// height pass. One item is in work at a time; a finished word waits in the output
// register while the next item is taken. Reset is synchronous, active low; the map is
// not cleared.
`default_nettype none

module grid_dda_ray_caster import gdrc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080,
    parameter int MAP_DIM       = 32,
    parameter int MAX_STEPS     = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_operation,
    input  wire logic [COL_W-1:0]      i_column,
    input  wire logic [CELL_W-1:0]     i_cell_x,
    input  wire logic [CELL_W-1:0]     i_cell_y,
    input  wire logic [VAL_W-1:0]      i_cell_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [ROW_W-1:0]      o_draw_top,
    output logic      [ROW_W-1:0]      o_draw_bottom,
    output logic                       o_hit_side,
    output logic      [1:0]            o_color_code,
    output logic                       o_hit_found
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    gdrc_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    gdrc_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_DIM       (MAP_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_column      (i_column),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_cell_value  (i_cell_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_draw_top    (o_draw_top),
        .o_draw_bottom (o_draw_bottom),
        .o_hit_side    (o_hit_side),
        .o_color_code  (o_color_code),
        .o_hit_found   (o_hit_found)
    );

    // A hit span is never inverted
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_found) |-> (o_draw_top <= o_draw_bottom))
        else $error("wall span inverted");

    // A miss reports an all-zero word
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit_found) |-> (o_draw_top == '0 && o_draw_bottom == '0 &&
                                       !o_hit_side && o_color_code == '0))
        else $error("miss word not cleared");

    // Color high bit follows the side that was hit
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_found) |-> (o_color_code[1] == o_hit_side))
        else $error("color does not match side");

endmodule

`default_nettype wire

[tb/ray_cast_checker.sv]
// Checker for the grid DDA ray caster: watches the config port and both channels.
// Keeps its own map and registers, predicts each cast word and compares in order.
// Depends on gdrc_pkg.
`timescale 1ns / 100ps

module ray_cast_checker import gdrc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_operation,
    input  wire logic [COL_W-1:0]      i_column,
    input  wire logic [CELL_W-1:0]     i_cell_x,
    input  wire logic [CELL_W-1:0]     i_cell_y,
    input  wire logic [VAL_W-1:0]      i_cell_value,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [ROW_W-1:0]      i_draw_top,
    input  wire logic [ROW_W-1:0]      i_draw_bottom,
    input  wire logic                  i_hit_side,
    input  wire logic [1:0]            i_color_code,
    input  wire logic                  i_hit_found,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint SCR_W   = 1920;
    localparam longint SCR_H   = 1080;
    localparam longint GRID    = 32;
    localparam int     WALK_MAX = 64;

    typedef struct packed {
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bottom;
        logic             side;
        logic [1:0]       color;
        logic             hit;
    } span_word_t;

    // Shadow state
    logic [14:0]    pos_x, pos_y;
    logic [15:0]    dir_x, dir_y, plane_x, plane_y;
    logic [VAL_W-1:0] grid_map [0:1023];
    span_word_t     span_q [$];

    assign o_pending = span_q.size();

    // Distance per cell crossed, Q16; an axis with no motion is never crossed
    function automatic longint unsigned cell_delta(input longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : longint'(d);
        return (a != 0) ? (64'd1 << 30) / a : (64'd1 << 40);
    endfunction

    function automatic span_word_t cast_span(input logic [COL_W-1:0] col_in);
        longint col, cam, rdx, rdy, mx, my, stx, sty;
        longint unsigned dx, dy, sx, sy, fx, fy, wall_d, height, half, top, bot;
        int side, hit;
        span_word_t w;
        side = 0;
        hit  = 0;
        col = col_in;
        if (col >= SCR_W) col = SCR_W - 1;
        cam = (2 * col * 16384) / SCR_W - 16384;
        // arithmetic shift floors the product
        rdx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 14);
        rdy = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 14);
        mx  = pos_x >> 10;
        my  = pos_y >> 10;
        dx  = cell_delta(rdx);
        dy  = cell_delta(rdy);
        stx = (rdx < 0) ? -1 : 1;
        sty = (rdy < 0) ? -1 : 1;
        fx  = (rdx < 0) ? pos_x[9:0] : 1024 - pos_x[9:0];
        fy  = (rdy < 0) ? pos_y[9:0] : 1024 - pos_y[9:0];
        sx  = (fx * dx) >> 10;
        sy  = (fy * dy) >> 10;
        // walk cell by cell, y wins ties
        for (int n = 0; n < WALK_MAX && hit == 0; n++) begin
            if (sx < sy) begin
                sx += dx; mx += stx; side = 0;
            end else begin
                sy += dy; my += sty; side = 1;
            end
            if (mx < 0 || my < 0 || mx >= GRID || my >= GRID)
                hit = 1;
            else if (grid_map[mx * GRID + my] != 0)
                hit = 1;
        end
        w = '0;
        if (hit == 0) return w;
        wall_d = (side == 0) ? sx - dx : sy - dy;
        height = (wall_d != 0) ? (SCR_H << 16) / wall_d : 0;
        half   = height / 2;
        top    = (half > SCR_H / 2) ? 0 : SCR_H / 2 - half;
        bot    = SCR_H / 2 + half;
        if (bot >= SCR_H) bot = SCR_H - 1;
        w.top    = top[ROW_W-1:0];
        w.bottom = bot[ROW_W-1:0];
        w.side   = side[0];
        if (side == 0) w.color = (stx < 0) ? 2'd0 : 2'd1;
        else           w.color = (sty < 0) ? 2'd2 : 2'd3;
        w.hit    = 1'b1;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        span_word_t got, want;
        if (!i_rst_n) begin
            pos_x   <= 15'd1024;
            pos_y   <= 15'd1024;
            dir_x   <= 16'hC000;
            dir_y   <= 16'd0;
            plane_x <= 16'd0;
            plane_y <= 16'd11469;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PLAYER_X: pos_x   <= i_cfg_wdata[14:0];
                    CFG_PLAYER_Y: pos_y   <= i_cfg_wdata[14:0];
                    CFG_VIEW_X:   dir_x   <= i_cfg_wdata;
                    CFG_VIEW_Y:   dir_y   <= i_cfg_wdata;
                    CFG_PLANE_X:  plane_x <= i_cfg_wdata;
                    CFG_PLANE_Y:  plane_y <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // input word: map write or cast
            if (i_valid && i_in_ready) begin
                if (i_operation == OP_WRITE)
                    grid_map[{i_cell_x, i_cell_y}] = i_cell_value;
                else
                    span_q.push_back(cast_span(i_column));
            end
            // output word
            if (i_out_valid && i_out_ready) begin
                got = '{i_draw_top, i_draw_bottom, i_hit_side, i_color_code, i_hit_found};
                if (span_q.size() == 0) begin
                    report_mismatch("words with nothing expected", 1, 0);
                end else begin
                    want = span_q.pop_front();
                    if (got.top != want.top)
                        report_mismatch("draw_top", got.top, want.top);
                    if (got.bottom != want.bottom)
                        report_mismatch("draw_bottom", got.bottom, want.bottom);
                    if (got.side != want.side)
                        report_mismatch("hit_side", got.side, want.side);
                    if (got.color != want.color)
                        report_mismatch("color_code", got.color, want.color);
                    if (got.hit != want.hit)
                        report_mismatch("hit_found", got.hit, want.hit);
                end
            end
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the grid DDA ray caster: clock, reset, stimulus and verdict.
// Depends on gdrc_pkg, grid_dda_ray_caster and ray_cast_checker.
`timescale 1ns / 100ps

module tb_top;
    import gdrc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid, o_ready, i_ready, o_valid;
    logic                  i_operation;
    logic [COL_W-1:0]      i_column;
    logic [CELL_W-1:0]     i_cell_x, i_cell_y;
    logic [VAL_W-1:0]      i_cell_value;
    logic [ROW_W-1:0]      o_draw_top, o_draw_bottom;
    logic                  o_hit_side, o_hit_found;
    logic [1:0]            o_color_code;
    int                    errors, pending;
    bit                    quiet;     // no idling in the closing part
    bit                    hold_req;  // ask the receiver for one long hold-off
    int                    idle_cycles;

    grid_dda_ray_caster DUT (.*);

    ray_cast_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_valid, .i_in_ready(o_ready), .i_operation, .i_column,
        .i_cell_x, .i_cell_y, .i_cell_value,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_draw_top(o_draw_top), .i_draw_bottom(o_draw_bottom),
        .i_hit_side(o_hit_side), .i_color_code(o_color_code),
        .i_hit_found(o_hit_found), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [COL_W-1:0] col,
                             input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                             input logic [VAL_W-1:0] val);
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_column     <= col;
        i_cell_x     <= cx;
        i_cell_y     <= cy;
        i_cell_value <= val;
        do @(posedge i_clk); while (!o_ready);
        // random sender gap after the word
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic cast_col(input logic [COL_W-1:0] col);
        send_word(OP_CAST, col, 5'($urandom), 5'($urandom), 3'($urandom));
    endtask

    task automatic write_cell(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                              input int wall_pct);
        logic [VAL_W-1:0] v;
        v = ($urandom_range(0, 99) < wall_pct) ? 3'($urandom_range(1, 7)) : 3'd0;
        send_word(OP_WRITE, 11'($urandom), cx, cy, v);
    endtask

    // Register writes only while the block is idle
    task automatic set_regs(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] vx, input logic [15:0] vy,
                            input logic [15:0] cx, input logic [15:0] cy);
        logic [15:0] vals [6];
        vals = '{px, py, vx, vy, cx, cy};
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= 3'(k);
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_q14();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    initial begin
        int wall_pct;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_wdata  <= '0;
        i_valid      <= 1'b0;
        i_operation  <= OP_WRITE;
        i_column     <= '0;
        i_cell_x     <= '0;
        i_cell_y     <= '0;
        i_cell_value <= '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every cell once so no cast reads an unwritten cell
        for (int x = 0; x < 32; x++)
            for (int y = 0; y < 32; y++)
                write_cell(5'(x), 5'(y), 15);

        // Directed casts with reset registers: edge columns and clamped columns
        cast_col(11'd0);
        cast_col(11'd1);
        cast_col(11'd959);
        cast_col(11'd960);
        cast_col(11'd1919);
        cast_col(11'd1920);
        cast_col(11'd2047);
        // Zero direction on both axes, player on a cell corner
        set_regs(16'd1024, 16'd1024, 16'd0, 16'd0, 16'd0, 16'd0);
        cast_col(11'd0);
        cast_col(11'd960);
        // Player at the origin, then at the far corner, with extreme vectors
        set_regs(16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        cast_col(11'd0);
        cast_col(11'd960);
        cast_col(11'd2047);
        cast_col(11'd1500);
        set_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        cast_col(11'd0);
        cast_col(11'd1919);
        cast_col(11'd700);
        // Axis-aligned rays from a mid cell, one along +x and one along -y
        set_regs(16'd16900, 16'd16100, 16'h4000, 16'h0000, 16'h0000, 16'h2000);
        cast_col(11'd960);
        set_regs(16'd16900, 16'd16100, 16'h0000, 16'hC000, 16'h2000, 16'h0000);
        cast_col(11'd960);

        // Random phases: registers, then a mix of map writes and casts
        for (int ph = 0; ph < 10; ph++) begin
            set_regs(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                     rnd_q14(), rnd_q14(), rnd_q14(), rnd_q14());
            wall_pct = $urandom_range(3, 40);
            if (ph == 8) quiet = 1'b1;
            for (int i = 0; i < 90; i++) begin
                if (ph == 3 && i == 10) hold_req = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    write_cell(5'($urandom), 5'($urandom), wall_pct);
                else if ($urandom_range(0, 9) == 0)
                    cast_col(11'($urandom));
                else
                    cast_col(11'($urandom_range(0, 1919)));
            end
        end

        // Drain
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
